### sv/vsa_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the voice slot allocator.
package vsa_pkg;

	localparam int VOICE_COUNT_DEF = 16;
	localparam int CFG_W = 5;

	typedef enum logic [1:0] {
		CMD_ALLOC        = 2'd0,
		CMD_STOP         = 2'd1,
		CMD_QUERY_SAMPLE = 2'd2,
		CMD_QUERY_ANY    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		cmd_t        command;
		logic [6:0]  emitter_id;
		logic [15:0] sample_id;
		logic [7:0]  variant;
		logic [1:0]  reuse_mode;
		logic [30:0] priority_req;
	} req_t;

	typedef struct packed {
		logic [3:0]  slot_index;
		logic        slot_valid;
		logic        evicted;
		logic [6:0]  evicted_emitter;
		logic [15:0] evicted_sample;
		logic [7:0]  evicted_variant;
		logic        query_hit;
		logic [4:0]  stopped_count;
	} rsp_t;

	// One stored voice entry; the active mark lives in flip-flops elsewhere.
	typedef struct packed {
		logic [6:0]  emitter;
		logic [15:0] sample;
		logic [7:0]  variant;
		logic [30:0] prio;
	} entry_t;

endpackage

### sv/vsa_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module vsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### sv/voice_slot_allocator.sv
`timescale 1ns / 1ps
// Voice slot allocator top level: command sequencer over the voice table.
//
// A command word is taken when start is high and busy is low. The block then
// reads the voice table from its RAM one entry per cycle over the first n
// entries (n is the scan size written through cfg_wr_data, clamped to
// 1..VOICE_COUNT), evaluates each entry in one shared compare unit, and
// decides and writes back in a final cycle. A command passes the scan state,
// a drain state for the last read word and the decision state. The result
// word is registered from the decision state and appears on rsp with done
// high for exactly one cycle; the receiver cannot stall it. busy stays high
// from the start edge until the result cycle, so a new word can be taken at
// the edge that ends the result cycle. The table is empty after reset.
module voice_slot_allocator #(
	parameter int VOICE_COUNT = vsa_pkg::VOICE_COUNT_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [vsa_pkg::CFG_W-1:0]  cfg_wr_data,
	input  logic                       start,
	input  vsa_pkg::req_t              req,
	output logic                       busy,
	output logic                       done,
	output vsa_pkg::rsp_t              rsp
);

	import vsa_pkg::*;

	localparam int IW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
	localparam int CW = $clog2(VOICE_COUNT + 1);
	localparam int CFGW = (CW > CFG_W) ? CW : CFG_W;

	state_t            state_q, state_d;
	logic [CFGW-1:0]   cfg_q;
	req_t              req_q;
	logic [IW-1:0]     iss_idx_q;
	logic              rd_vld_q;
	logic [IW-1:0]     rd_idx_q;
	logic [VOICE_COUNT-1:0] active_q;
	logic              reuse_found_q, free_found_q;
	logic [IW-1:0]     reuse_idx_q, free_idx_q, low_idx_q;
	entry_t            low_entry_q;
	logic [CW-1:0]     count_q;
	logic              hit_q;
	logic              done_q;
	rsp_t              rsp_q;

	int unsigned       n_scan;
	logic [IW-1:0]     last_idx;
	logic              ram_re, ram_we;
	entry_t            ram_rdata, ram_wdata;
	logic [IW-1:0]     slot;
	logic              grant, steal, reuse_hit;
	logic              ent_act, em_hit, full_hit, lower;
	rsp_t              rsp_d;

	always_comb begin
		n_scan = 32'(cfg_q);
		if (n_scan < 1) begin
			n_scan = 1;
		end
		if (n_scan > VOICE_COUNT) begin
			n_scan = VOICE_COUNT;
		end
		last_idx = IW'(n_scan - 1);
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (iss_idx_q == last_idx) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN:  state_d = ST_FINISH;
			ST_FINISH: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		busy   = 1'b1;
		ram_re = 1'b0;
		ram_we = 1'b0;
		unique case (state_q)
			ST_IDLE:   busy = 1'b0;
			ST_SCAN:   ram_re = 1'b1;
			ST_DRAIN:  ;
			ST_FINISH: ram_we = (req_q.command == CMD_ALLOC) && grant;
			default:   busy = 1'b1;
		endcase
	end

	// Shared entry evaluation on the word just read from the table.
	always_comb begin
		ent_act  = active_q[rd_idx_q];
		em_hit   = ent_act && (ram_rdata.emitter == req_q.emitter_id);
		full_hit = em_hit && (ram_rdata.sample == req_q.sample_id)
			&& (ram_rdata.variant == req_q.variant);
		lower    = ram_rdata.prio < low_entry_q.prio;
	end

	// Allocation decision after the pass.
	always_comb begin
		reuse_hit = req_q.reuse_mode[1] && reuse_found_q;
		steal     = 1'b0;
		grant     = 1'b1;
		slot      = low_idx_q;
		priority if (reuse_hit) begin
			slot = reuse_idx_q;
		end else if (free_found_q) begin
			slot = free_idx_q;
		end else if (low_entry_q.prio < req_q.priority_req) begin
			steal = 1'b1;
		end else begin
			grant = 1'b0;
		end
	end

	// Result word of the command, formed in the decision cycle.
	always_comb begin
		rsp_d = '0;
		unique case (req_q.command)
			CMD_ALLOC: begin
				if (grant) begin
					rsp_d.slot_index = 4'(slot);
					rsp_d.slot_valid = 1'b1;
					rsp_d.query_hit  = reuse_hit;
					if (steal) begin
						rsp_d.evicted         = 1'b1;
						rsp_d.evicted_emitter = low_entry_q.emitter;
						rsp_d.evicted_sample  = low_entry_q.sample;
						rsp_d.evicted_variant = low_entry_q.variant;
					end
				end
			end
			CMD_STOP:         rsp_d.stopped_count = 5'(count_q);
			CMD_QUERY_SAMPLE: rsp_d.query_hit = hit_q;
			CMD_QUERY_ANY:    rsp_d.query_hit = hit_q;
			default:          rsp_d = '0;
		endcase
	end

	assign ram_wdata = '{emitter: req_q.emitter_id, sample: req_q.sample_id,
		variant: req_q.variant, prio: req_q.priority_req};

	vsa_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(VOICE_COUNT)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(slot),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(iss_idx_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cfg_q         <= CFGW'(VOICE_COUNT);
			iss_idx_q     <= '0;
			rd_vld_q      <= 1'b0;
			active_q      <= '0;
			reuse_found_q <= 1'b0;
			free_found_q  <= 1'b0;
			count_q       <= '0;
			hit_q         <= 1'b0;
			done_q        <= 1'b0;
		end else begin
			state_q  <= state_d;
			rd_vld_q <= (state_q == ST_SCAN);
			done_q   <= (state_q == ST_FINISH);
			if (cfg_wr_en) begin
				cfg_q <= CFGW'(cfg_wr_data);
			end
			if (state_q == ST_IDLE && start) begin
				iss_idx_q     <= '0;
				reuse_found_q <= 1'b0;
				free_found_q  <= 1'b0;
				count_q       <= '0;
				hit_q         <= 1'b0;
			end
			if (state_q == ST_SCAN) begin
				iss_idx_q <= iss_idx_q + IW'(1);
			end
			if (rd_vld_q) begin
				if (full_hit && !reuse_found_q) begin
					reuse_found_q <= 1'b1;
				end
				if (!ent_act && !free_found_q) begin
					free_found_q <= 1'b1;
				end
				if (req_q.command == CMD_STOP && em_hit) begin
					count_q            <= count_q + CW'(1);
					active_q[rd_idx_q] <= 1'b0;
				end
				if ((req_q.command == CMD_QUERY_ANY && em_hit)
					|| (req_q.command == CMD_QUERY_SAMPLE && full_hit)) begin
					hit_q <= 1'b1;
				end
			end
			if (ram_we) begin
				active_q[slot] <= 1'b1;
			end
		end
	end

	// Payload registers of the scan and the result word.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			req_q <= req;
		end
		rd_idx_q <= iss_idx_q;
		if (rd_vld_q) begin
			if (full_hit && !reuse_found_q) begin
				reuse_idx_q <= rd_idx_q;
			end
			if (!ent_act && !free_found_q) begin
				free_idx_q <= rd_idx_q;
			end
			// The first entry seeds the lowest-priority search.
			if (rd_idx_q == '0 || lower) begin
				low_idx_q   <= rd_idx_q;
				low_entry_q <= ram_rdata;
			end
		end
		if (state_q == ST_FINISH) begin
			rsp_q <= rsp_d;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

### bench/voice_slot_checker.sv
`timescale 1ns / 1ps
// Checker that predicts each voice slot allocator result word and compares it.
module voice_slot_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [vsa_pkg::CFG_W-1:0] cfg_wr_data,
	input  logic                      start,
	input  logic                      busy,
	input  vsa_pkg::req_t             req,
	input  logic                      done,
	input  vsa_pkg::rsp_t             rsp,
	output int                        errors,
	output int                        outstanding
);

	import vsa_pkg::*;

	localparam int VN = VOICE_COUNT_DEF;
	// Allocation modes from this value up may reuse a matching active voice.
	localparam logic [1:0] MODE_REUSE = 2'd2;

	bit              v_on   [VN];
	bit [6:0]        v_emit [VN];
	bit [15:0]       v_smpl [VN];
	bit [7:0]        v_var  [VN];
	bit [30:0]       v_prio [VN];
	bit [CFG_W-1:0]  scan_cfg;
	rsp_t            reply_q[$];
	rsp_t            want;
	int              bad;

	function automatic int scan_span();
		if (scan_cfg == 0)
			return 1;
		if (scan_cfg > VN)
			return VN;
		return int'(scan_cfg);
	endfunction

	// Applies one request word to the table copy and returns its result word.
	function automatic rsp_t resolve_request(req_t w);
		rsp_t r;
		int   n;
		int   i;
		int   slot;
		int   low;
		int   cnt;
		bit   found;
		r = '0;
		n = scan_span();
		slot = 0;
		cnt = 0;
		found = 1'b0;
		case (w.command)
		CMD_ALLOC: begin
			if (w.reuse_mode >= MODE_REUSE) begin
				for (i = 0; i < n && !found; i++) begin
					if (v_on[i] && v_emit[i] == w.emitter_id && v_smpl[i] == w.sample_id &&
					    v_var[i] == w.variant) begin
						slot = i;
						found = 1'b1;
						r.query_hit = 1'b1;
					end
				end
			end
			for (i = 0; i < n && !found; i++) begin
				if (!v_on[i]) begin
					slot = i;
					found = 1'b1;
				end
			end
			if (!found) begin
				low = 0;
				for (i = 1; i < n; i++)
					if (v_prio[i] < v_prio[low])
						low = i;
				// Stealing needs a strictly lower stored priority.
				if (v_prio[low] >= w.priority_req)
					return r;
				slot = low;
				r.evicted = 1'b1;
				r.evicted_emitter = v_emit[low];
				r.evicted_sample = v_smpl[low];
				r.evicted_variant = v_var[low];
			end
			v_on[slot] = 1'b1;
			v_emit[slot] = w.emitter_id;
			v_smpl[slot] = w.sample_id;
			v_var[slot] = w.variant;
			v_prio[slot] = w.priority_req;
			r.slot_index = slot[3:0];
			r.slot_valid = 1'b1;
		end
		CMD_STOP: begin
			for (i = 0; i < n; i++) begin
				if (v_on[i] && v_emit[i] == w.emitter_id) begin
					v_on[i] = 1'b0;
					cnt++;
				end
			end
			r.stopped_count = cnt[4:0];
		end
		default: begin
			for (i = 0; i < n; i++) begin
				if (v_on[i] && v_emit[i] == w.emitter_id &&
				    (w.command == CMD_QUERY_ANY ||
				     (v_smpl[i] == w.sample_id && v_var[i] == w.variant)))
					r.query_hit = 1'b1;
			end
		end
		endcase
		return r;
	endfunction

	function automatic int field_bad(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < VN; i++) begin
				v_on[i] = 1'b0;
				v_emit[i] = '0;
				v_smpl[i] = '0;
				v_var[i] = '0;
				v_prio[i] = '0;
			end
			scan_cfg = CFG_W'(VN);
			reply_q.delete();
			outstanding = 0;
			errors = 0;
		end else begin
			// A finishing word is checked before a word accepted at the same edge.
			if (done) begin
				if (reply_q.size() == 0) begin
					$display("%0t: result word with none expected, actual %h", $time, rsp);
					errors++;
				end else begin
					want = reply_q.pop_front();
					bad = 0;
					bad += field_bad("slot_index", 32'(want.slot_index),
						32'(rsp.slot_index));
					bad += field_bad("slot_valid", 32'(want.slot_valid),
						32'(rsp.slot_valid));
					bad += field_bad("evicted", 32'(want.evicted), 32'(rsp.evicted));
					bad += field_bad("evicted_emitter", 32'(want.evicted_emitter),
						32'(rsp.evicted_emitter));
					bad += field_bad("evicted_sample", 32'(want.evicted_sample),
						32'(rsp.evicted_sample));
					bad += field_bad("evicted_variant", 32'(want.evicted_variant),
						32'(rsp.evicted_variant));
					bad += field_bad("query_hit", 32'(want.query_hit),
						32'(rsp.query_hit));
					bad += field_bad("stopped_count", 32'(want.stopped_count),
						32'(rsp.stopped_count));
					if (bad != 0)
						errors++;
				end
			end
			if (cfg_wr_en)
				scan_cfg = cfg_wr_data;
			if (start && !busy)
				reply_q.push_back(resolve_request(req));
			outstanding = reply_q.size();
		end
	end

endmodule

### bench/tb_voice_slot_allocator.sv
`timescale 1ns / 1ps
// Testbench top: drives request words and scan settings into the voice slot allocator.
module tb_voice_slot_allocator;
	import vsa_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int PHASES = 9;
	localparam int PHASE_WORDS = 160;
	localparam logic [1:0] MODE_FRESH     = 2'd0;
	localparam logic [1:0] MODE_FRESH_ALT = 2'd1;
	localparam logic [1:0] MODE_REUSE     = 2'd2;
	localparam logic [1:0] MODE_REUSE_ALT = 2'd3;
	localparam logic [30:0] PRIO_TOP = 31'h7FFF_FFFF;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [CFG_W-1:0] cfg_wr_data;
	logic             start;
	req_t             req;
	logic             busy;
	logic             done;
	rsp_t             rsp;
	int               errors;
	int               outstanding;
	int               quiet_cycles = 0;
	bit   [4:0]       scan_plan [PHASES];
	bit               idle_on;

	always #6 clk = ~clk;

	voice_slot_allocator DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.start      (start),
		.req        (req),
		.busy       (busy),
		.done       (done),
		.rsp        (rsp)
	);

	voice_slot_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.start      (start),
		.busy       (busy),
		.req        (req),
		.done       (done),
		.rsp        (rsp),
		.errors     (errors),
		.outstanding(outstanding)
	);

	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic req_t make_word(cmd_t c, bit [6:0] e, bit [15:0] s, bit [7:0] v,
	                                   bit [1:0] m, bit [30:0] p);
		req_t w;
		w.command = c;
		w.emitter_id = e;
		w.sample_id = s;
		w.variant = v;
		w.reuse_mode = m;
		w.priority_req = p;
		return w;
	endfunction

	// Keys come mostly from small pools so that reuse, query hits and stealing happen often.
	function automatic req_t random_word();
		req_t w;
		int   pick;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			w.command = CMD_ALLOC;
		else if (pick < 62)
			w.command = CMD_STOP;
		else if (pick < 82)
			w.command = CMD_QUERY_SAMPLE;
		else
			w.command = CMD_QUERY_ANY;
		pick = $urandom_range(0, 9);
		w.emitter_id = (pick < 7) ? 7'($urandom_range(0, 3)) :
		               (pick == 7) ? 7'd127 : 7'($urandom_range(0, 127));
		pick = $urandom_range(0, 9);
		w.sample_id = (pick < 5) ? 16'($urandom_range(0, 2)) :
		              (pick < 7) ? 16'hFFFF : 16'($urandom);
		pick = $urandom_range(0, 9);
		w.variant = (pick < 6) ? 8'($urandom_range(0, 1)) :
		            (pick < 7) ? 8'hFF : 8'($urandom);
		w.reuse_mode = 2'($urandom_range(0, 3));
		pick = $urandom_range(0, 9);
		w.priority_req = (pick < 6) ? 31'($urandom_range(0, 7)) :
		                 (pick < 8) ? PRIO_TOP : 31'($urandom);
		return w;
	endfunction

	task automatic wait_drained();
		do
			@(negedge clk);
		while (outstanding != 0 || busy);
	endtask

	// Holds the word on the inputs until the block takes it.
	task automatic send(req_t w);
		start <= 1'b1;
		req <= w;
		do
			@(posedge clk);
		while (busy);
	endtask

	task automatic set_scan(bit [4:0] v);
		start <= 1'b0;
		wait_drained();
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		start <= 1'b0;
		req <= '0;
		scan_plan = '{5'd16, 5'd0, 5'd1, 5'd31, 5'd17, 5'd5, 5'd0, 5'd8, 5'd16};
		scan_plan[6] = 5'($urandom_range(0, 31));
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Two scanned entries make the full table and stealing reachable quickly.
		set_scan(5'd2);
		send(make_word(CMD_QUERY_ANY, 7'd0, 16'd0, 8'd0, MODE_FRESH, 31'd0));
		send(make_word(CMD_ALLOC, 7'd0, 16'd0, 8'd0, MODE_FRESH, 31'd0));
		send(make_word(CMD_ALLOC, 7'd127, 16'hFFFF, 8'hFF, MODE_FRESH_ALT, PRIO_TOP));
		send(make_word(CMD_ALLOC, 7'd5, 16'd1, 8'd1, MODE_FRESH, 31'd0));
		send(make_word(CMD_ALLOC, 7'd5, 16'd1, 8'd1, MODE_FRESH, 31'd1));
		send(make_word(CMD_ALLOC, 7'd127, 16'hFFFF, 8'hFF, MODE_REUSE, 31'd3));
		send(make_word(CMD_ALLOC, 7'd5, 16'd1, 8'd1, MODE_REUSE_ALT, 31'd2));
		send(make_word(CMD_ALLOC, 7'd9, 16'd2, 8'd2, MODE_REUSE, 31'd5));
		send(make_word(CMD_QUERY_SAMPLE, 7'd127, 16'hFFFF, 8'hFF, MODE_FRESH, 31'd0));
		send(make_word(CMD_QUERY_SAMPLE, 7'd127, 16'hFFFF, 8'hFE, MODE_FRESH, 31'd0));
		send(make_word(CMD_QUERY_ANY, 7'd9, 16'd0, 8'd0, MODE_FRESH, 31'd0));
		send(make_word(CMD_QUERY_ANY, 7'd0, 16'd0, 8'd0, MODE_FRESH, 31'd0));
		send(make_word(CMD_STOP, 7'd127, 16'd0, 8'd0, MODE_FRESH, 31'd0));
		send(make_word(CMD_STOP, 7'd127, 16'd0, 8'd0, MODE_FRESH, 31'd0));
		send(make_word(CMD_ALLOC, 7'd0, 16'hFFFF, 8'd0, MODE_REUSE_ALT, PRIO_TOP));
		send(make_word(CMD_ALLOC, 7'd1, 16'd0, 8'hFF, MODE_FRESH, PRIO_TOP));
		send(make_word(CMD_ALLOC, 7'd2, 16'd7, 8'd7, MODE_REUSE, PRIO_TOP));
		send(make_word(CMD_QUERY_SAMPLE, 7'd0, 16'hFFFF, 8'd0, MODE_FRESH, 31'd0));
		send(make_word(CMD_STOP, 7'd0, 16'd0, 8'd0, MODE_FRESH, 31'd0));
		send(make_word(CMD_STOP, 7'd1, 16'd0, 8'd0, MODE_FRESH, 31'd0));

		for (int p = 0; p < PHASES; p++) begin
			set_scan(scan_plan[p]);
			idle_on = 1'b0;
			for (int k = 0; k < PHASE_WORDS; k++) begin
				if (k % 20 == 0)
					idle_on = (p < PHASES - 1) && ($urandom_range(0, 2) != 0);
				send(random_word());
				if (idle_on && $urandom_range(0, 2) == 0) begin
					// The gap starts once the block is ready again, so it is seen as idle input.
					start <= 1'b0;
					do
						@(posedge clk);
					while (busy);
					repeat ($urandom_range(0, 6)) @(posedge clk);
				end
			end
		end

		start <= 1'b0;
		wait_drained();
		repeat (30) @(posedge clk);
		if (errors == 0 && outstanding == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

### sim.f
sv/vsa_pkg.sv
sv/vsa_ram.sv
sv/voice_slot_allocator.sv
bench/voice_slot_checker.sv
bench/tb_voice_slot_allocator.sv
